// File: rtl/core/espo_pkg.sv
// Shared types and constants of the expert slot offset planner.
// Used by espo_ctrl, espo_dp and expert_slot_offset_planner.
package espo_pkg;

   localparam int DEF_RANKS         = 8;
   localparam int DEF_EXPERTS       = 2;
   localparam int DEF_SLOT_CAPACITY = 16;

   localparam logic [1:0] OP_LOAD_LOCAL  = 2'd0;
   localparam logic [1:0] OP_LOAD_REMOTE = 2'd1;
   localparam logic [1:0] OP_ASSEMBLE    = 2'd2;

   localparam logic KIND_TOTAL = 1'b0;
   localparam logic KIND_SLOT  = 1'b1;

   localparam int OFFSET_W = 9;
   localparam int TOTAL_W  = 8;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        expert_index;
      logic [2:0]  source_rank;
      logic [15:0] token_count;
   } req_word_type;

   typedef struct packed {
      logic       kind;
      logic       expert_id;
      logic [2:0] from_rank;
      logic [3:0] slot_number;
      logic [7:0] source_row;
      logic [8:0] dest_row;
      logic [7:0] row_count;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic take;
      logic clear_wr;
      logic idx_clear;
      logic idx_step;
      logic rd;
      logic acc;
      logic sum_clear;
      logic emit_total;
      logic emit_slot;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_assemble;
      logic slot_last;
      logic expert_last;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/core/espo_ram.sv
// Generic single write port RAM with a registered read port.
// No dependencies.
module espo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/espo_ctrl.sv
// Sequencer of the planner: clearing pass, loads, sum pass, totals, descriptors.
// Depends on espo_pkg.
module espo_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  espo_pkg::dp_status_type status,
   output espo_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_TOTAL,
      ST_SLOT_RD,
      ST_SLOT_OUT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.slot_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.idx_step = 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && status.is_assemble) begin
               cmd.idx_clear = 1'b1;
               cmd.sum_clear = 1'b1;
               state_in      = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.acc = 1'b1;
            if (status.slot_last) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_TOTAL;
            end else begin
               cmd.idx_step = 1'b1;
               state_in     = ST_SUM_RD;
            end
         end
         ST_TOTAL: begin
            if (status.out_free) begin
               cmd.emit_total = 1'b1;
               if (status.expert_last) begin
                  cmd.idx_clear = 1'b1;
                  cmd.sum_clear = 1'b1;
                  state_in      = ST_SLOT_RD;
               end else begin
                  cmd.idx_step = 1'b1;
               end
            end
         end
         ST_SLOT_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_SLOT_OUT;
         end
         ST_SLOT_OUT: begin
            if (status.out_free) begin
               cmd.emit_slot = 1'b1;
               if (status.slot_last) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_SLOT_RD;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/core/espo_dp.sv
// Datapath of the planner: count stores, slot walk, prefix sum, output register.
// Depends on espo_pkg and espo_ram.
module espo_dp #(
   parameter int RANKS         = espo_pkg::DEF_RANKS,
   parameter int EXPERTS       = espo_pkg::DEF_EXPERTS,
   parameter int SLOT_CAPACITY = espo_pkg::DEF_SLOT_CAPACITY
) (
   input  logic                    clock,
   input  logic                    reset,
   input  espo_pkg::ctrl_cmd_type  cmd,
   output espo_pkg::dp_status_type status,
   input  espo_pkg::req_word_type  req_data,
   input  logic                    csr_wr_en,
   input  logic [2:0]              csr_wr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output espo_pkg::rsp_word_type  rsp_data
);

   localparam int SLOTS  = EXPERTS * RANKS;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int RANK_W = $clog2(RANKS);
   localparam int EXP_W  = (EXPERTS > 1) ? $clog2(EXPERTS) : 1;
   localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
   localparam int SROW_W = SLOT_W + 9;
   localparam int OFS_W  = espo_pkg::OFFSET_W;
   localparam int TOT_W  = espo_pkg::TOTAL_W;

   logic [2:0]       own_rank_ff, own_rank_in;
   logic [CNT_W-1:0] local_ff [EXPERTS];
   logic [CNT_W-1:0] local_in [EXPERTS];
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [EXP_W-1:0]  expert_ff, expert_in;
   logic [OFS_W-1:0]  offset_ff, offset_in;
   logic [OFS_W-1:0]  start_ff [EXPERTS];
   logic [OFS_W-1:0]  start_in [EXPERTS];
   logic [TOT_W-1:0]  total_ff [EXPERTS];
   logic [TOT_W-1:0]  total_in [EXPERTS];
   logic              rsp_valid_ff, rsp_valid_in;
   espo_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  load_cnt;
   logic              exp_ok;
   logic              rank_ok;
   logic              load_local;
   logic              load_remote;
   logic [SLOT_W-1:0] load_addr;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [CNT_W-1:0]  ram_wr_data;
   logic [CNT_W-1:0]  ram_rd_data;
   logic [CNT_W-1:0]  slot_cnt;
   logic [EXP_W-1:0]  exp_sel;
   logic [SROW_W-1:0] source_row;

   assign load_cnt = (req_data.token_count > 16'(SLOT_CAPACITY)) ?
                     CNT_W'(SLOT_CAPACITY) : CNT_W'(req_data.token_count);
   assign exp_ok   = (32'(req_data.expert_index) < EXPERTS);
   assign rank_ok  = (32'(req_data.source_rank) < RANKS);
   assign load_local  = cmd.take && (req_data.opcode == espo_pkg::OP_LOAD_LOCAL) && exp_ok;
   assign load_remote = cmd.take && (req_data.opcode == espo_pkg::OP_LOAD_REMOTE) &&
                        exp_ok && rank_ok;
   assign load_addr = req_data.expert_index ?
                      SLOT_W'(RANKS) + SLOT_W'(req_data.source_rank) :
                      SLOT_W'(req_data.source_rank);

   assign ram_wr_en   = cmd.clear_wr || load_remote;
   assign ram_wr_addr = cmd.clear_wr ? idx_ff : load_addr;
   assign ram_wr_data = cmd.clear_wr ? '0 : load_cnt;

   espo_ram #(
      .WIDTH (CNT_W),
      .DEPTH (SLOTS)
   ) u_remote_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign slot_cnt   = (32'(rank_ff) == 32'(own_rank_ff)) ? local_ff[expert_ff] : ram_rd_data;
   assign exp_sel    = EXP_W'(idx_ff);
   assign source_row = SROW_W'(idx_ff) * SROW_W'(SLOT_CAPACITY);

   assign status.is_assemble = (req_data.opcode == espo_pkg::OP_ASSEMBLE);
   assign status.slot_last   = (idx_ff == SLOT_W'(SLOTS - 1));
   assign status.expert_last = (idx_ff == SLOT_W'(EXPERTS - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      own_rank_in = csr_wr_en ? csr_wr_data : own_rank_ff;

      local_in = local_ff;
      if (load_local) begin
         local_in[EXP_W'(req_data.expert_index)] = load_cnt;
      end

      idx_in    = idx_ff;
      rank_in   = rank_ff;
      expert_in = expert_ff;
      if (cmd.idx_clear) begin
         idx_in    = '0;
         rank_in   = '0;
         expert_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + SLOT_W'(1);
         if (rank_ff == RANK_W'(RANKS - 1)) begin
            rank_in   = '0;
            expert_in = expert_ff + EXP_W'(1);
         end else begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end

      offset_in = offset_ff;
      if (cmd.sum_clear) begin
         offset_in = '0;
      end else if (cmd.acc || cmd.emit_slot) begin
         offset_in = offset_ff + OFS_W'(slot_cnt);
      end

      start_in = start_ff;
      total_in = total_ff;
      if (cmd.acc) begin
         if (rank_ff == '0) begin
            start_in[expert_ff] = offset_ff;
            total_in[expert_ff] = TOT_W'(slot_cnt);
         end else begin
            total_in[expert_ff] = total_ff[expert_ff] + TOT_W'(slot_cnt);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit_total) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = espo_pkg::KIND_TOTAL;
         rsp_data_in.expert_id   = 1'(idx_ff);
         rsp_data_in.from_rank   = '0;
         rsp_data_in.slot_number = '0;
         rsp_data_in.source_row  = '0;
         rsp_data_in.dest_row    = start_ff[exp_sel];
         rsp_data_in.row_count   = total_ff[exp_sel];
         rsp_data_in.last        = 1'b0;
      end else if (cmd.emit_slot) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = espo_pkg::KIND_SLOT;
         rsp_data_in.expert_id   = 1'(expert_ff);
         rsp_data_in.from_rank   = 3'(rank_ff);
         rsp_data_in.slot_number = 4'(idx_ff);
         rsp_data_in.source_row  = 8'(source_row);
         rsp_data_in.dest_row    = offset_ff;
         rsp_data_in.row_count   = 8'(slot_cnt);
         rsp_data_in.last        = status.slot_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_rank_ff  <= '0;
         idx_ff       <= '0;
         rank_ff      <= '0;
         expert_ff    <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < EXPERTS; i++) begin
            local_ff[i] <= '0;
         end
      end else begin
         own_rank_ff  <= own_rank_in;
         idx_ff       <= idx_in;
         rank_ff      <= rank_in;
         expert_ff    <= expert_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
         local_ff     <= local_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/expert_slot_offset_planner.sv
// Top level of the expert slot offset planner.
// Depends on espo_pkg, espo_ctrl, espo_dp and espo_ram.
//
// Count loads are accepted back to back. An assemble word walks the remote
// count RAM, which has a single registered read port, over its SLOTS entries
// (SLOTS = EXPERTS*RANKS) once to build the prefix sum and expert totals,
// emits the expert totals, and walks it once more to emit the descriptors;
// no new word is taken meanwhile. The last result may still wait in the output
// register while the next word is taken. After reset a clearing pass zeroes
// the remote count RAM before the first word is taken; csr writes are taken
// at any time.
module expert_slot_offset_planner #(
   parameter int RANKS         = espo_pkg::DEF_RANKS,
   parameter int EXPERTS       = espo_pkg::DEF_EXPERTS,
   parameter int SLOT_CAPACITY = espo_pkg::DEF_SLOT_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  espo_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output espo_pkg::rsp_word_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_wr_data
);

   espo_pkg::ctrl_cmd_type  cmd;
   espo_pkg::dp_status_type status;

   espo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   espo_dp #(
      .RANKS         (RANKS),
      .EXPERTS       (EXPERTS),
      .SLOT_CAPACITY (SLOT_CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == espo_pkg::OP_ASSEMBLE) |=> !req_ready)
      else $error("assemble word did not stall the request side");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == espo_pkg::KIND_TOTAL) |->
      (rsp_data.from_rank == '0 && rsp_data.slot_number == '0 &&
       rsp_data.source_row == '0 && !rsp_data.last))
      else $error("expert total word carries slot fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.kind == espo_pkg::KIND_SLOT))
      else $error("last flag on a word that is not a descriptor");

endmodule
